@@ src/locd_pkg.sv @@
// shared constants, status codes and types for the lock order cycle detector
package locd_pkg;

  localparam int MAX_LOCKS   = 16;
  localparam int NUM_THREADS = 4;
  localparam int STACK_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int ID_OUT_W = 4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MULTI    = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_DEADLOCK = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_HALTED   = 3'd5;
  localparam logic [2:0] ST_STACK    = 3'd6;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic done;
    logic found;
  } dfs_stat_t;

endpackage

@@ src/locd_dfs.sv @@
// iterative depth-first search engine with tree parent store
module locd_dfs #(
  parameter int MaxLocks = locd_pkg::MAX_LOCKS,
  parameter int IW       = $clog2(MaxLocks),
  parameter int CW       = $clog2(MaxLocks + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CW-1:0]       count_i,
  input  logic [MaxLocks-1:0] adj_row_i,
  input  logic [IW-1:0]       par_addr_i,
  output logic [IW-1:0]       par_data_o,
  output logic [IW-1:0]       here_o,
  output logic [IW-1:0]       from_o,
  output logic [IW-1:0]       to_o,
  output locd_pkg::dfs_stat_t stat_o
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_ROOT = 2'd1;
  localparam logic [1:0] D_SCAN = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [MaxLocks-1:0] seen_q, seen_d, fin_q, fin_d;
  logic [CW-1:0]       root_q, root_d, t_q, t_d;
  logic [IW-1:0]       here_q, here_d, from_q, from_d, to_q, to_d;
  logic [IW-1:0]       parent_q [MaxLocks];
  logic                par_we;
  logic [IW-1:0]       par_wa;
  logic [IW-1:0]       par_ra;
  logic [IW-1:0]       par_rd;
  logic [IW-1:0]       t_idx;
  logic                done_d, found_d;
  logic                done_q, found_q;

  assign par_ra     = (state_q == D_IDLE) ? par_addr_i : here_q;
  assign par_rd     = parent_q[par_ra];
  assign par_data_o = par_rd;
  assign here_o     = here_q;
  assign from_o     = from_q;
  assign to_o       = to_q;
  assign stat_o     = '{done: done_q, found: found_q};
  assign t_idx      = t_q[IW-1:0];

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    fin_d   = fin_q;
    root_d  = root_q;
    t_d     = t_q;
    here_d  = here_q;
    from_d  = from_q;
    to_d    = to_q;
    par_we  = 1'b0;
    par_wa  = t_idx;
    done_d  = 1'b0;
    found_d = found_q;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          seen_d  = '0;
          fin_d   = '0;
          root_d  = '0;
          state_d = D_ROOT;
        end
      end
      D_ROOT: begin
        if (root_q >= count_i) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          state_d = D_IDLE;
        end else if (seen_q[root_q[IW-1:0]]) begin
          root_d = root_q + 1'b1;
        end else begin
          seen_d[root_q[IW-1:0]] = 1'b1;
          here_d  = root_q[IW-1:0];
          t_d     = '0;
          state_d = D_SCAN;
        end
      end
      D_SCAN: begin
        if (t_q >= count_i) begin
          fin_d[here_q] = 1'b1;
          if (CW'(here_q) == root_q) begin
            root_d  = root_q + 1'b1;
            state_d = D_ROOT;
          end else begin
            t_d    = CW'(here_q) + 1'b1;
            here_d = par_rd;
          end
        end else if (!adj_row_i[t_idx]) begin
          t_d = t_q + 1'b1;
        end else if (!seen_q[t_idx]) begin
          par_we        = 1'b1;
          par_wa        = t_idx;
          seen_d[t_idx] = 1'b1;
          here_d        = t_idx;
          t_d           = '0;
        end else if (!fin_q[t_idx]) begin
          from_d  = here_q;
          to_d    = t_idx;
          done_d  = 1'b1;
          found_d = 1'b1;
          state_d = D_IDLE;
        end else begin
          t_d = t_q + 1'b1;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      seen_q  <= '0;
      fin_q   <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      fin_q   <= fin_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    t_q    <= t_d;
    here_q <= here_d;
    from_q <= from_d;
    to_q   <= to_d;
    if (par_we) begin
      parent_q[par_wa] <= here_q;
    end
  end

endmodule

@@ src/lock_order_cycle_detector_core.sv @@
// top level: key lookup, held-lock stacks, order matrix and result sequencing
//
//  port group   dir  handshake              contents
//  in           in   in_valid_i/in_ready_o  mode, thread, lock_key
//  out          out  out_valid_o/out_ready_i status, lock_id, edge_from, edge_to, last
//
// one item at a time: key lookup checks the known keys in turn (up to MaxLocks),
// then the result and stack update are decided; a new order edge starts a search
// that steps one adjacency bit per cycle.
// a deadlock sends up to MAX_RESULTS items, one per accepted output.
// reset clears counts, heights, the order matrix and the halt flag.
// in_ready_o is low while an item is in work or a result waits.
module lock_order_cycle_detector_core #(
  parameter int MaxLocks   = locd_pkg::MAX_LOCKS,
  parameter int NumThreads = locd_pkg::NUM_THREADS,
  parameter int StackDepth = locd_pkg::STACK_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [1:0]  thread_i,
  input  logic [15:0] lock_key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  lock_id_o,
  output logic [3:0]  edge_from_o,
  output logic [3:0]  edge_to_o,
  output logic        last_o
);

  localparam int IW  = $clog2(MaxLocks);
  localparam int CW  = $clog2(MaxLocks + 1);
  localparam int TW  = (NumThreads > 1) ? $clog2(NumThreads) : 1;
  localparam int HW  = $clog2(StackDepth + 1);
  localparam int MD  = NumThreads * StackDepth;
  localparam int AW  = $clog2(MD);
  localparam int OW  = locd_pkg::ID_OUT_W;
  localparam int ChainMax = (locd_pkg::MAX_RESULTS - 1 < MaxLocks) ?
                            locd_pkg::MAX_RESULTS - 1 : MaxLocks;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_CHAIN = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                halted_q, halted_d;
  logic [CW-1:0]       count_q, count_d;
  logic [15:0]         keys_q [MaxLocks];
  logic [MaxLocks-1:0] adj_q [MaxLocks];
  logic [HW-1:0]       hgt_q [NumThreads];
  logic [IW-1:0]       held_mem [MD];
  logic [IW-1:0]       top_q;

  logic                mode_q;
  logic [TW-1:0]       th_q;
  logic [15:0]         key_q;
  logic [CW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       id_q, id_d;
  logic                fnd_q, fnd_d;
  logic [HW-1:0]       h_q;
  logic [IW-1:0]       now_q, now_d;
  logic [IW-1:0]       to_q, to_d;
  logic [3:0]          cnt_q, cnt_d;

  logic                ov_q, ov_d, olast_q, olast_d;
  logic [2:0]          ost_q, ost_d;
  logic [OW-1:0]       oid_q, oid_d, ofr_q, ofr_d, oto_q, oto_d;

  logic [4:0]          th_ext;
  logic [TW-1:0]       th_in;
  logic [HW-1:0]       h_in;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                accept;
  logic                key_we, adj_set, push, pop, dfs_start;
  logic [IW-1:0]       id_n;
  logic [IW-1:0]       adj_addr;
  logic [MaxLocks-1:0] adj_row;

  logic [IW-1:0]       dfs_here, dfs_from, dfs_to, par_data;
  locd_pkg::dfs_stat_t dfs_stat;

  always_comb begin
    th_ext = {3'b000, thread_i};
    for (int k = 0; k < 4; k++) begin
      if (th_ext >= 5'(NumThreads)) begin
        th_ext = th_ext - 5'(NumThreads);
      end
    end
  end
  assign th_in = TW'(th_ext);
  assign h_in  = hgt_q[th_in];

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign rd_addr    = AW'(th_in) * AW'(StackDepth) + AW'(h_in - 1'b1);
  assign wr_addr    = AW'(th_q) * AW'(StackDepth) + AW'(h_q);

  assign adj_addr = (state_q == S_SRCH) ? dfs_here : top_q;
  assign adj_row  = adj_q[adj_addr];

  assign out_valid_o = ov_q;
  assign status_o    = ost_q;
  assign lock_id_o   = oid_q;
  assign edge_from_o = ofr_q;
  assign edge_to_o   = oto_q;
  assign last_o      = olast_q;

  locd_dfs #(
    .MaxLocks(MaxLocks),
    .IW      (IW),
    .CW      (CW)
  ) u_dfs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dfs_start),
    .count_i   (count_q),
    .adj_row_i (adj_row),
    .par_addr_i(now_q),
    .par_data_o(par_data),
    .here_o    (dfs_here),
    .from_o    (dfs_from),
    .to_o      (dfs_to),
    .stat_o    (dfs_stat)
  );

  always_comb begin
    state_d   = state_q;
    halted_d  = halted_q;
    count_d   = count_q;
    idx_d     = idx_q;
    id_d      = id_q;
    fnd_d     = fnd_q;
    now_d     = now_q;
    to_d      = to_q;
    cnt_d     = cnt_q;
    ov_d      = ov_q && !out_ready_i;
    ost_d     = ost_q;
    oid_d     = oid_q;
    ofr_d     = ofr_q;
    oto_d     = oto_q;
    olast_d   = olast_q;
    key_we    = 1'b0;
    adj_set   = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    dfs_start = 1'b0;
    id_n      = id_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (halted_q) begin
            ov_d = 1'b1; ost_d = locd_pkg::ST_HALTED; oid_d = '0;
            ofr_d = '0; oto_d = '0; olast_d = 1'b1;
          end else begin
            idx_d   = '0;
            fnd_d   = 1'b0;
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (idx_q == count_q) begin
          state_d = S_DEC;
        end else if (keys_q[idx_q[IW-1:0]] == key_q) begin
          fnd_d   = 1'b1;
          id_d    = idx_q[IW-1:0];
          state_d = S_DEC;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DEC: begin
        state_d = S_IDLE;
        ov_d    = 1'b1;
        ofr_d   = '0;
        oto_d   = '0;
        olast_d = 1'b1;
        oid_d   = fnd_q ? OW'(id_q) : '0;
        if (mode_q == locd_pkg::MODE_RELEASE) begin
          if (h_q == '0) begin
            ost_d = locd_pkg::ST_MULTI;
          end else if (!fnd_q || top_q != id_q) begin
            ost_d = locd_pkg::ST_INVALID;
          end else begin
            pop   = 1'b1;
            ost_d = locd_pkg::ST_OK;
          end
        end else if (h_q >= HW'(StackDepth)) begin
          ost_d = locd_pkg::ST_STACK;
        end else if (!fnd_q && count_q >= CW'(MaxLocks)) begin
          ost_d = locd_pkg::ST_FULL;
        end else begin
          if (!fnd_q) begin
            id_n    = count_q[IW-1:0];
            key_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
          id_d  = id_n;
          oid_d = OW'(id_n);
          ost_d = locd_pkg::ST_OK;
          if (h_q != '0 && top_q != id_n && !adj_row[id_n]) begin
            adj_set   = 1'b1;
            dfs_start = 1'b1;
            ov_d      = 1'b0;
            state_d   = S_SRCH;
          end else begin
            push = 1'b1;
          end
        end
      end
      S_SRCH: begin
        if (dfs_stat.done) begin
          ov_d  = 1'b1;
          oid_d = OW'(id_q);
          if (dfs_stat.found) begin
            halted_d = 1'b1;
            ost_d    = locd_pkg::ST_DEADLOCK;
            ofr_d    = OW'(dfs_from);
            oto_d    = OW'(dfs_to);
            olast_d  = 1'b0;
            now_d    = dfs_from;
            to_d     = dfs_to;
            cnt_d    = '0;
            state_d  = S_CHAIN;
          end else begin
            push    = 1'b1;
            ost_d   = locd_pkg::ST_OK;
            ofr_d   = '0;
            oto_d   = '0;
            olast_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_CHAIN: begin
        if (!ov_q) begin
          ov_d    = 1'b1;
          ost_d   = locd_pkg::ST_DEADLOCK;
          ofr_d   = OW'(par_data);
          oto_d   = OW'(now_q);
          olast_d = (par_data == to_q) || (cnt_q == 4'(ChainMax - 1));
          now_d   = par_data;
          cnt_d   = cnt_q + 1'b1;
          if ((par_data == to_q) || (cnt_q == 4'(ChainMax - 1))) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      halted_q <= 1'b0;
      count_q  <= '0;
      ov_q     <= 1'b0;
      for (int i = 0; i < MaxLocks; i++) begin
        adj_q[i] <= '0;
      end
      for (int i = 0; i < NumThreads; i++) begin
        hgt_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      halted_q <= halted_d;
      count_q  <= count_d;
      ov_q     <= ov_d;
      if (adj_set) begin
        adj_q[top_q][id_n] <= 1'b1;
      end
      if (push) begin
        hgt_q[th_q] <= h_q + 1'b1;
      end else if (pop) begin
        hgt_q[th_q] <= h_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      th_q   <= th_in;
      key_q  <= lock_key_i;
      h_q    <= h_in;
      top_q  <= held_mem[rd_addr];
    end
    if (push) begin
      held_mem[wr_addr] <= id_n;
    end
    if (key_we) begin
      keys_q[count_q[IW-1:0]] <= key_q;
    end
    idx_q   <= idx_d;
    id_q    <= id_d;
    fnd_q   <= fnd_d;
    now_q   <= now_d;
    to_q    <= to_d;
    cnt_q   <= cnt_d;
    ost_q   <= ost_d;
    oid_q   <= oid_d;
    ofr_q   <= ofr_d;
    oto_q   <= oto_d;
    olast_q <= olast_d;
  end

endmodule

@@ dv/tb_lock_order_cycle_detector_core.sv @@
// testbench for the lock order cycle detector: random and directed lock events, predicted results
module tb_lock_order_cycle_detector_core;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] lock_id;
    logic [3:0] edge_from;
    logic [3:0] edge_to;
    logic       last;
  } lock_result_t;

  class lock_order_board;
    logic [15:0] keys[locd_pkg::MAX_LOCKS];
    int          nkeys;
    logic [15:0] order[locd_pkg::MAX_LOCKS];
    logic [3:0]  held[locd_pkg::NUM_THREADS][locd_pkg::STACK_DEPTH];
    int          height[locd_pkg::NUM_THREADS];
    int          rank[locd_pkg::MAX_LOCKS];
    bit          seen[locd_pkg::MAX_LOCKS];
    bit          done[locd_pkg::MAX_LOCKS];
    logic [3:0]  parent[locd_pkg::MAX_LOCKS];
    bit          stopped;
    int          rank_nxt, cyc_from, cyc_to;
    lock_result_t pending[$];
    int          errors;

    function new();
      nkeys = 0;
      stopped = 0;
      errors = 0;
      foreach (order[i]) order[i] = '0;
      foreach (height[i]) height[i] = 0;
    endfunction

    function void push(logic [2:0] st, int id, int ef, int et, bit lst);
      lock_result_t r;
      r.status = st;
      r.lock_id = id[3:0];
      r.edge_from = ef[3:0];
      r.edge_to = et[3:0];
      r.last = lst;
      pending.push_back(r);
    endfunction

    function automatic bit dfs(int here);
      seen[here] = 1;
      rank[here] = rank_nxt++;
      for (int t = 0; t < nkeys; t++) begin
        if (!order[here][t]) continue;
        if (!seen[t]) begin
          parent[t] = here[3:0];
          if (dfs(t)) return 1;
          continue;
        end
        if (rank[here] < rank[t]) continue;
        if (!done[t]) begin
          cyc_from = here;
          cyc_to = t;
          return 1;
        end
      end
      done[here] = 1;
      return 0;
    endfunction

    function bit has_cycle();
      foreach (seen[i]) begin
        seen[i] = 0;
        done[i] = 0;
      end
      rank_nxt = 0;
      for (int i = 0; i < nkeys; i++)
        if (!seen[i] && dfs(i)) return 1;
      return 0;
    endfunction

    function void note_item(logic mode, logic [1:0] th, logic [15:0] key);
      int h, found, id, n, now;
      h = height[th];
      found = -1;
      if (stopped) begin
        push(locd_pkg::ST_HALTED, 0, 0, 0, 1);
        return;
      end
      for (int i = 0; i < nkeys; i++)
        if (found < 0 && keys[i] == key) found = i;
      if (mode == locd_pkg::MODE_RELEASE) begin
        if (h == 0) push(locd_pkg::ST_MULTI, found < 0 ? 0 : found, 0, 0, 1);
        else if (found < 0) push(locd_pkg::ST_INVALID, 0, 0, 0, 1);
        else if (held[th][h-1] != found) push(locd_pkg::ST_INVALID, found, 0, 0, 1);
        else begin
          height[th] = h - 1;
          push(locd_pkg::ST_OK, found, 0, 0, 1);
        end
        return;
      end
      if (h >= locd_pkg::STACK_DEPTH) begin
        push(locd_pkg::ST_STACK, found < 0 ? 0 : found, 0, 0, 1);
        return;
      end
      if (found < 0) begin
        if (nkeys >= locd_pkg::MAX_LOCKS) begin
          push(locd_pkg::ST_FULL, 0, 0, 0, 1);
          return;
        end
        id = nkeys;
        keys[id] = key;
        nkeys++;
      end else id = found;
      if (h > 0 && held[th][h-1] != id && !order[held[th][h-1]][id]) begin
        order[held[th][h-1]][id] = 1;
        if (has_cycle()) begin
          push(locd_pkg::ST_DEADLOCK, id, cyc_from, cyc_to, 0);
          n = 1;
          now = cyc_from;
          for (int g = 0; g < locd_pkg::MAX_LOCKS && n < locd_pkg::MAX_RESULTS; g++) begin
            push(locd_pkg::ST_DEADLOCK, id, parent[now], now, 0);
            n++;
            now = parent[now];
            if (now == cyc_to) break;
          end
          pending[$].last = 1;
          stopped = 1;
          return;
        end
      end
      held[th][h] = id[3:0];
      height[th] = h + 1;
      push(locd_pkg::ST_OK, id, 0, 0, 1);
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", exp, got);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, mode_i, out_valid_o, out_ready_i, last_o;
  logic [1:0]  thread_i;
  logic [15:0] lock_key_i;
  logic [2:0]  status_o;
  logic [3:0]  lock_id_o, edge_from_o, edge_to_o;

  lock_order_cycle_detector_core dut (.*);

  lock_order_board board = new();
  bit   quiet;
  int   stall_left;
  int   idle_cycles;
  logic [15:0] pool[8];

  initial begin
    clk_i = 0;
    forever begin
      #5 clk_i = 1;
      #5 clk_i = 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_result({status_o, lock_id_o, edge_from_o, edge_to_o, last_o});
      if (in_valid_i && in_ready_o)
        board.note_item(mode_i, thread_i, lock_key_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb_lock_order_cycle_detector_core: done, errors");
        $finish;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 16) - 1;
        out_ready_i <= 0;
      end else out_ready_i <= 1;
    end
  end

  task automatic send(logic mode, logic [1:0] th, logic [15:0] key);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i <= mode;
    thread_i <= th;
    lock_key_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic random_phase(int cnt, int nk);
    logic [15:0] k;
    for (int i = 0; i < cnt; i++) begin
      k = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[$urandom_range(0, nk - 1)];
      send($urandom_range(0, 2) == 0, 2'($urandom_range(0, 3)), k);
    end
  endtask

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    mode_i = 0;
    thread_i = 0;
    lock_key_i = 0;
    out_ready_i = 1;
    quiet = 0;
    stall_left = 0;
    idle_cycles = 0;
    foreach (pool[i]) pool[i] = 16'($urandom);
    pool[0] = 16'h0000;
    pool[1] = 16'hffff;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty-stack release, unknown release, nesting, wrong top, re-acquire
    send(locd_pkg::MODE_RELEASE, 0, 16'h0000);
    send(locd_pkg::MODE_ACQUIRE, 0, 16'h0000);
    send(locd_pkg::MODE_RELEASE, 0, 16'h1234);
    send(locd_pkg::MODE_ACQUIRE, 0, 16'hffff);
    send(locd_pkg::MODE_ACQUIRE, 0, 16'hffff);
    send(locd_pkg::MODE_RELEASE, 0, 16'h0000);
    send(locd_pkg::MODE_RELEASE, 0, 16'hffff);
    send(locd_pkg::MODE_RELEASE, 0, 16'hffff);
    send(locd_pkg::MODE_RELEASE, 0, 16'h0000);
    send(locd_pkg::MODE_RELEASE, 3, 16'hffff);
    // stack full on thread 3, then table full on thread 2
    for (int i = 0; i < locd_pkg::STACK_DEPTH + 1; i++)
      send(locd_pkg::MODE_ACQUIRE, 3, 16'h00a5);
    for (int i = 0; i < locd_pkg::STACK_DEPTH; i++)
      send(locd_pkg::MODE_RELEASE, 3, 16'h00a5);
    for (int i = 0; i < 14; i++) send(locd_pkg::MODE_ACQUIRE, 2, 16'h5a00 + 16'(i));
    send(locd_pkg::MODE_ACQUIRE, 2, 16'h7777);
    for (int i = 13; i >= 0; i--) send(locd_pkg::MODE_RELEASE, 2, 16'h5a00 + 16'(i));
    quiet = 1;
    drain();
    quiet = 0;
    // random: mostly pool keys, random modes and threads; deadlock and halted follow
    for (int i = 0; i < 8; i++) pool[i] = (i < 2) ? (i == 0 ? 16'h0000 : 16'hffff)
                                                 : 16'h5a00 + 16'(i);
    random_phase(60, 8);
    // thread 1 acquires in opposite order to force a cycle if still running
    send(locd_pkg::MODE_ACQUIRE, 0, 16'h5a02);
    send(locd_pkg::MODE_ACQUIRE, 0, 16'h5a03);
    send(locd_pkg::MODE_ACQUIRE, 1, 16'h5a03);
    send(locd_pkg::MODE_ACQUIRE, 1, 16'h5a02);
    quiet = 1;
    random_phase(30, 8);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_lock_order_cycle_detector_core: done, clean");
    end else begin
      $display("tb_lock_order_cycle_detector_core: done, errors");
    end
    $finish;
  end
endmodule

@@ files.f @@
src/locd_pkg.sv
src/locd_dfs.sv
src/lock_order_cycle_detector_core.sv
dv/tb_lock_order_cycle_detector_core.sv
